>>> rtl/fpa_pkg.sv
`timescale 1ns / 1ps
package fpa_pkg;

    localparam int FRAC_BITS_DEFAULT = 8;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_COMPARE  = 4'd4,
        CMD_INC      = 4'd5,
        CMD_DEC      = 4'd6,
        CMD_FROM_INT = 4'd7,
        CMD_TO_INT   = 4'd8,
        CMD_MIN      = 4'd9,
        CMD_MAX      = 4'd10
    } t_cmd;

endpackage

>>> rtl/fixed_point_alu.sv
`timescale 1ns / 1ps
// Signed 32-bit fixed-point ALU, FRAC_BITS fraction bits.
// Input channel: i_in_valid / o_in_ready carry i_command, i_operand_a and
// i_operand_b. Output channel: o_out_valid / i_out_ready carry o_result and
// the five flags. Every input transaction gives exactly one output
// transaction, in order.
// Pipeline: r_front, the divider stages r_div[0..NW], r_round, then the
// output registers r_out / r_res / r_ovf. The depth is set by the
// divider, which resolves one quotient bit per stage over 32 + FRAC_BITS
// stages; all other commands ride along the same pipeline.
// Throughput: one transaction per cycle, back to back, while the receiver does not stall.
// Reset clears every stage valid bit; the pipeline comes up empty and ready.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_in_ready drops; once the output is taken or empty, everything
// advances again and nothing is lost or repeated.
module fixed_point_alu #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [3:0]         i_command,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_result,
    output logic               o_less_flag,
    output logic               o_greater_flag,
    output logic               o_equal_flag,
    output logic               o_overflow_flag,
    output logic               o_divide_by_zero_flag
);
    import fpa_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam int QW = NW + 1;

    typedef struct packed {
        logic               valid;
        logic [3:0]         cmd;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [63:0] prod;
    } t_front;

    typedef struct packed {
        logic               valid;
        logic [3:0]         cmd;
        logic [31:0]        res;
        logic               ovf;
        logic               lt;
        logic               gt;
        logic               eq;
        logic               dz;
        logic               is_div;
        logic               neg;
        logic [NW-1:0]      num;
        logic [31:0]        den;
        logic [31:0]        rem;
        logic [NW-1:0]      quo;
    } t_div;

    typedef struct packed {
        logic               valid;
        logic [3:0]         cmd;
        logic [31:0]        res;
        logic               ovf;
        logic               lt;
        logic               gt;
        logic               eq;
        logic               dz;
        logic               is_div;
        logic               neg;
        logic [QW-1:0]      q;
    } t_round;

    function automatic logic [32:0] sat64(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > 64'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -64'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    logic   w_adv;
    t_front r_front;
    t_front n_front;
    t_div   r_div [0:NW];
    t_div   n_div [0:NW];
    t_round r_round;
    t_round n_round;
    t_round r_out;
    logic [31:0] r_res;
    logic [31:0] n_res;
    logic        r_ovf;
    logic        n_ovf;

    assign w_adv      = !r_out.valid || i_out_ready;
    assign o_in_ready = w_adv;

    always_comb begin
        n_front.valid = i_in_valid;
        n_front.cmd   = i_command;
        n_front.a     = i_operand_a;
        n_front.b     = i_operand_b;
        n_front.prod  = 64'(i_operand_a) * 64'(i_operand_b);
    end

    // front end: every command but a nonzero divide, and divider setup
    always_comb begin
        logic signed [63:0] a64;
        logic signed [63:0] b64;
        logic [63:0]        pmag;
        logic [63:0]        m;
        logic signed [63:0] mv;
        logic [32:0]        s;
        logic [31:0]        ua;
        logic [31:0]        ub;
        logic [32:0]        t;
        a64  = 64'(r_front.a);
        b64  = 64'(r_front.b);
        pmag = r_front.prod[63] ? (~r_front.prod + 64'd1) : r_front.prod;
        m    = (pmag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        mv   = r_front.prod[63] ? -$signed(m) : $signed(m);
        ua   = r_front.a[31] ? (~r_front.a + 32'd1) : r_front.a;
        ub   = r_front.b[31] ? (~r_front.b + 32'd1) : r_front.b;
        s    = 33'd0;
        n_div[0].valid = r_front.valid;
        n_div[0].cmd   = r_front.cmd;
        n_div[0].lt    = r_front.a < r_front.b;
        n_div[0].gt    = r_front.a > r_front.b;
        n_div[0].eq    = r_front.a == r_front.b;
        n_div[0].dz    = 1'b0;
        n_div[0].is_div = 1'b0;
        n_div[0].neg   = r_front.a[31] ^ r_front.b[31];
        n_div[0].num   = {ua, {FRAC_BITS{1'b0}}};
        n_div[0].den   = ub;
        n_div[0].rem   = 32'd0;
        n_div[0].quo   = '0;
        case (r_front.cmd)
            CMD_ADD:      s = sat64(a64 + b64);
            CMD_SUB:      s = sat64(a64 - b64);
            CMD_MUL:      s = sat64(mv);
            CMD_DIV: begin
                if (r_front.b == 32'sd0) begin
                    n_div[0].dz = 1'b1;
                    if (r_front.a > 32'sd0) begin
                        s = {1'b0, 32'h7FFF_FFFF};
                    end else if (r_front.a < 32'sd0) begin
                        s = {1'b0, 32'h8000_0000};
                    end
                end else begin
                    n_div[0].is_div = 1'b1;
                end
            end
            CMD_INC:      s = sat64(a64 + 64'sd1);
            CMD_DEC:      s = sat64(a64 - 64'sd1);
            CMD_FROM_INT: s = sat64(a64 <<< FRAC_BITS);
            CMD_TO_INT:   s = {1'b0, 32'(r_front.a >>> FRAC_BITS)};
            CMD_MIN:      s = {1'b0, (r_front.a < r_front.b) ? r_front.a : r_front.b};
            CMD_MAX:      s = {1'b0, (r_front.a > r_front.b) ? r_front.a : r_front.b};
            default:      s = 33'd0;
        endcase
        n_div[0].ovf = s[32];
        n_div[0].res = s[31:0];

        // one quotient bit per stage
        for (int k = 1; k <= NW; k++) begin
            t        = {r_div[k-1].rem, r_div[k-1].num[NW-1]};
            n_div[k] = r_div[k-1];
            n_div[k].num = r_div[k-1].num << 1;
            if (t >= {1'b0, r_div[k-1].den}) begin
                n_div[k].rem = 32'(t - {1'b0, r_div[k-1].den});
                n_div[k].quo = {r_div[k-1].quo[NW-2:0], 1'b1};
            end else begin
                n_div[k].rem = t[31:0];
                n_div[k].quo = {r_div[k-1].quo[NW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        n_round.valid  = r_div[NW].valid;
        n_round.cmd    = r_div[NW].cmd;
        n_round.res    = r_div[NW].res;
        n_round.ovf    = r_div[NW].ovf;
        n_round.lt     = r_div[NW].lt;
        n_round.gt     = r_div[NW].gt;
        n_round.eq     = r_div[NW].eq;
        n_round.dz     = r_div[NW].dz;
        n_round.is_div = r_div[NW].is_div;
        n_round.neg    = r_div[NW].neg;
        n_round.q      = {1'b0, r_div[NW].quo};
        if ({r_div[NW].rem, 1'b0} >= {1'b0, r_div[NW].den}) begin
            n_round.q = {1'b0, r_div[NW].quo} + QW'(1);
        end
    end

    always_comb begin
        logic hi;
        hi    = |r_round.q[QW-1:32];
        n_res = r_round.res;
        n_ovf = r_round.ovf;
        if (r_round.is_div) begin
            if (r_round.neg) begin
                if (hi || (r_round.q[31] && (|r_round.q[30:0]))) begin
                    n_res = 32'h8000_0000;
                    n_ovf = 1'b1;
                end else begin
                    n_res = ~r_round.q[31:0] + 32'd1;
                    n_ovf = 1'b0;
                end
            end else begin
                if (hi || r_round.q[31]) begin
                    n_res = 32'h7FFF_FFFF;
                    n_ovf = 1'b1;
                end else begin
                    n_res = r_round.q[31:0];
                    n_ovf = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
            for (int k = 0; k <= NW; k++) begin
                r_div[k].valid <= 1'b0;
            end
            r_round.valid <= 1'b0;
            r_out.valid   <= 1'b0;
        end else if (w_adv) begin
            r_front <= n_front;
            for (int k = 0; k <= NW; k++) begin
                r_div[k] <= n_div[k];
            end
            r_round <= n_round;
            r_out   <= r_round;
            r_res   <= n_res;
            r_ovf   <= n_ovf;
        end
    end

    assign o_out_valid           = r_out.valid;
    assign o_result              = r_res;
    assign o_less_flag           = r_out.lt;
    assign o_greater_flag        = r_out.gt;
    assign o_equal_flag          = r_out.eq;
    assign o_overflow_flag       = r_ovf;
    assign o_divide_by_zero_flag = r_out.dz;

`ifndef ASSERT_OFF
    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot({o_less_flag, o_greater_flag, o_equal_flag}))
        else $error("comparison flags not one-hot");

    a_dz_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_divide_by_zero_flag |-> !o_overflow_flag && r_out.cmd == CMD_DIV)
        else $error("divide by zero with overflow or wrong command");

    a_compare_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_out.cmd == CMD_COMPARE |-> o_result == 32'd0 && !o_overflow_flag)
        else $error("compare result not zero");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div[0].valid && !w_adv |=> r_div[0].valid && $stable(r_div[0].res))
        else $error("pipeline stage moved during stall");
`endif

endmodule
